// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms; every use sits on clk with rst disabling.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold the implication in the same cycle
`define XCA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// hold the implication in the next cycle
`define XCA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/xca_pkg.sv =====
// ----------------------------------------------------------------------------
// xca_pkg
// Types, sizes and palette of the XOR-chain automaton pixel generator.
// ----------------------------------------------------------------------------
package xca_pkg;

  localparam int ROW_CELLS   = 400;
  localparam int FRAME_LINES = 240;
  localparam int RAND_CELLS  = 16;

  localparam int COL_W  = $clog2(ROW_CELLS);
  localparam int LINE_W = (FRAME_LINES > 1) ? $clog2(FRAME_LINES) : 1;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [3:0]        cell_t;

  typedef enum logic [1:0] {
    REQ_PIXEL   = 2'd0,
    REQ_SEED    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_IGNORE  = 2'd3
  } req_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } phase_t;

  typedef struct packed {
    logic  tag;
    cell_t prev;
    cell_t cur;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    req_t  op;
    col_t  addr;
    cell_t value;
    line_t line;
    logic  row_end;
    logic  frm_end;
  } item_t;

  typedef struct packed {
    logic clearing;
    col_t addr;
  } clear_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam logic [7:0] C_LO = 8'd0;
  localparam logic [7:0] C_MD = 8'd128;
  localparam logic [7:0] C_HI = 8'd255;

  function automatic rgb_t palette(cell_t k);
    rgb_t c;
    unique case (k)
      4'd0:  c = '{C_LO, C_LO, C_LO};
      4'd1:  c = '{C_LO, C_HI, C_LO};
      4'd2:  c = '{C_LO, C_LO, C_HI};
      4'd3:  c = '{C_HI, C_HI, C_LO};
      4'd4:  c = '{C_MD, C_MD, C_HI};
      4'd5:  c = '{C_HI, C_LO, C_LO};
      4'd6:  c = '{C_LO, C_HI, C_MD};
      4'd7:  c = '{C_MD, C_LO, C_HI};
      4'd8:  c = '{C_HI, C_HI, C_LO};
      4'd9:  c = '{C_HI, C_LO, C_MD};
      4'd10: c = '{C_HI, C_MD, C_LO};
      4'd11: c = '{C_MD, C_HI, C_LO};
      4'd12: c = '{C_LO, C_LO, C_HI};
      4'd13: c = '{C_MD, C_HI, C_LO};
      4'd14: c = '{C_LO, C_MD, C_MD};
      4'd15: c = '{C_HI, C_HI, C_HI};
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/xca_cell_ram.sv =====
// ----------------------------------------------------------------------------
// xca_cell_ram
// Single-port-write, single-port-read RAM, registered read, write-first.
// ----------------------------------------------------------------------------
module xca_cell_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/xca_front.sv =====
// ----------------------------------------------------------------------------
// xca_front
// Request intake: clearing pass, raster counters, read issue, item register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xca_front import xca_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] req_type,
  input  logic [8:0] cell_index,
  input  logic [3:0] cell_value,
  input  logic       s1_go,
  output item_t      item,
  output logic       item_valid,
  output clear_t     clr,
  output logic       rd_en,
  output col_t       rd_addr
);

  phase_t phase;
  phase_t phase_next;
  col_t   clr_cnt;
  col_t   column_count;
  line_t  line_count;

  req_t        op_in;
  logic [31:0] idx_wide;
  col_t        seed_addr;
  logic        seed_ok;
  logic        row_end;
  logic        frm_end;
  logic        accept;
  item_t       item_next;

  always_comb begin
    unique case (phase)
      ST_CLEAR: phase_next = (clr_cnt == col_t'(ROW_CELLS - 1)) ? ST_RUN : ST_CLEAR;
      ST_RUN:   phase_next = ST_RUN;
    endcase
  end

  always_comb begin
    clr.clearing = (phase == ST_CLEAR);
    clr.addr     = clr_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      phase <= phase_next;
      if (phase == ST_CLEAR) begin
        clr_cnt <= clr_cnt + col_t'(1);
      end
    end
  end

  assign op_in     = req_t'(req_type);
  assign idx_wide  = 32'(cell_index);
  assign seed_addr = idx_wide[COL_W-1:0];
  assign seed_ok   = idx_wide < 32'(ROW_CELLS);
  assign row_end   = (column_count == col_t'(ROW_CELLS - 1));
  assign frm_end   = row_end && (line_count == line_t'(FRAME_LINES - 1));

  assign req_stall = clr.clearing || (item_valid && !s1_go);
  assign accept    = req_valid && !req_stall;
  assign rd_en     = accept && (op_in == REQ_PIXEL);
  assign rd_addr   = column_count;

  always_comb begin
    item_next.op      = op_in;
    item_next.addr    = column_count;
    item_next.value   = cell_value;
    item_next.line    = line_count;
    item_next.row_end = row_end;
    item_next.frm_end = frm_end;
    unique case (op_in)
      REQ_SEED: begin
        item_next.addr = seed_addr;
        if (!seed_ok) begin
          item_next.op = REQ_IGNORE;
        end
      end
      REQ_PIXEL, REQ_RESTART, REQ_IGNORE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      column_count <= '0;
      line_count   <= '0;
    end else begin
      if (accept) begin
        item_valid <= 1'b1;
      end else if (s1_go) begin
        item_valid <= 1'b0;
      end
      if (accept && (op_in == REQ_PIXEL)) begin
        column_count <= row_end ? '0 : column_count + col_t'(1);
        if (row_end) begin
          line_count <= frm_end ? '0 : line_count + line_t'(1);
        end
      end else if (accept && (op_in == REQ_RESTART)) begin
        column_count <= '0;
        line_count   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

  `XCA_ASSERT_SAME(a_clear_blocks_req, clr.clearing, req_stall, "word taken during clearing pass")
  `XCA_ASSERT_NEXT(a_item_held, item_valid && !s1_go, item_valid && $stable(item), "waiting item lost")
  `XCA_ASSERT_SAME(a_col_range, 1'b1, 32'(column_count) < 32'(ROW_CELLS), "column out of row")

endmodule

// ===== hw/rtl/xca_exec.sv =====
// ----------------------------------------------------------------------------
// xca_exec
// Cell update: XOR chain, row epoch, low-cell shadow, output word register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xca_exec import xca_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  logic       item_valid,
  input  entry_t     rd_data,
  input  clear_t     clr,
  output logic       s1_go,
  output logic       wr_en,
  output col_t       wr_addr,
  output entry_t     wr_data,
  output logic       pix_valid,
  input  logic       pix_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [3:0] cell_out,
  output logic [8:0] column,
  output logic [7:0] line,
  output logic       frame_end
);

  localparam logic [31:0] LAST_COL = 32'(ROW_CELLS - 1);

  logic  epoch;
  cell_t run;
  cell_t shadow [RAND_CELLS];

  logic        out_free;
  logic        pix_go;
  cell_t       prev_eff;
  cell_t       k;
  rgb_t        rgb;
  logic [31:0] col_wide;
  logic [31:0] line_wide;

  assign out_free = !pix_valid || !pix_stall;
  assign s1_go    = item_valid && ((item.op != REQ_PIXEL) || out_free);
  assign pix_go   = s1_go && (item.op == REQ_PIXEL);
  assign prev_eff = (rd_data.tag == epoch) ? rd_data.prev : rd_data.cur;
  assign k        = run ^ prev_eff ^ shadow[run];
  assign rgb      = palette(k);
  assign col_wide  = 32'(item.addr);
  assign line_wide = 32'(item.line);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = item.addr;
    wr_data = '{tag: epoch, prev: prev_eff, cur: k};
    if (clr.clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr.addr;
      wr_data = '{tag: epoch, prev: 4'd0, cur: 4'd0};
    end else if (pix_go) begin
      wr_en = 1'b1;
    end else if (s1_go && (item.op == REQ_SEED)) begin
      wr_en   = 1'b1;
      wr_data = '{tag: epoch, prev: 4'd0, cur: item.value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= 1'b0;
      run   <= '0;
      for (int i = 0; i < RAND_CELLS; i++) begin
        shadow[i] <= '0;
      end
    end else begin
      if (wr_en && (wr_addr < col_t'(RAND_CELLS))) begin
        shadow[wr_addr[3:0]] <= wr_data.cur;
      end
      if (pix_go) begin
        run <= k;
        if (item.row_end) begin
          epoch <= ~epoch;
        end
      end else if (s1_go && (item.op == REQ_RESTART)) begin
        run <= item.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (out_free) begin
      pix_valid <= pix_go;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_go) begin
      red       <= rgb.r;
      green     <= rgb.g;
      blue      <= rgb.b;
      cell_out  <= k;
      column    <= col_wide[8:0];
      line      <= line_wide[7:0];
      frame_end <= item.frm_end;
    end
  end

  `XCA_ASSERT_NEXT(a_epoch_flip, pix_go && item.row_end, epoch != $past(epoch), "row end missed epoch flip")
  `XCA_ASSERT_NEXT(a_word_loaded, pix_go, pix_valid && (cell_out == $past(k)), "pixel word not loaded")
  `XCA_ASSERT_SAME(a_frame_end_col, pix_valid && frame_end, column == LAST_COL[8:0], "frame end off row end")

endmodule

// ===== hw/rtl/xor_chain_automaton_pixel_gen.sv =====
// ----------------------------------------------------------------------------
// xor_chain_automaton_pixel_gen
// XOR-chain 1D automaton of 4-bit cells rendered as a palette raster.
// ----------------------------------------------------------------------------
// One request word is taken per clock while req_stall is low. A pixel word
// takes the cell RAM read, then the output register, and an output stall
// can hold it in between. After reset the cell RAM is cleared, one column
// per cycle; req_stall stays high until all ROW_CELLS (400) are cleared.
// Each RAM entry holds the current cell, the saved previous-row cell and a
// row tag; a row end flips the tag sense, which stands in for copying the
// row, so a row end adds no stall. Cells 0 to 15 are also held in registers
// for the indexed lookup of the chain.
// ----------------------------------------------------------------------------
module xor_chain_automaton_pixel_gen import xca_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] req_type,
  input  logic [8:0] cell_index,
  input  logic [3:0] cell_value,
  output logic       pix_valid,
  input  logic       pix_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [3:0] cell_out,
  output logic [8:0] column,
  output logic [7:0] line,
  output logic       frame_end
);

  item_t  item;
  logic   item_valid;
  clear_t clr;
  logic   s1_go;
  logic   rd_en;
  col_t   rd_addr;
  logic   wr_en;
  col_t   wr_addr;
  entry_t wr_data;
  entry_t rd_data;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic [ENTRY_W-1:0] ram_rd_data;

  assign ram_wr_data = ENTRY_W'(wr_data);
  assign rd_data     = entry_t'(ram_rd_data);

  xca_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .cell_index (cell_index),
    .cell_value (cell_value),
    .s1_go      (s1_go),
    .item       (item),
    .item_valid (item_valid),
    .clr        (clr),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  xca_cell_ram #(
    .DEPTH (ROW_CELLS),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  xca_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .rd_data    (rd_data),
    .clr        (clr),
    .s1_go      (s1_go),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cell_out   (cell_out),
    .column     (column),
    .line       (line),
    .frame_end  (frame_end)
  );

endmodule

// ===== test/xor_chain_automaton_pixel_gen_tb.sv =====
// ----------------------------------------------------------------------------
// xor_chain_automaton_pixel_gen_tb
// Drives request words into the pixel generator and checks each pixel word
// against a cycle-free XOR-chain automaton model in the bench, or a typed word.
// A directed table covers seed, restart, ignored and out-of-range requests,
// then random traffic runs past row ends with random gaps and stalls on
// both channels, one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module xor_chain_automaton_pixel_gen_tb;
  import xca_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_WORDS    = 1525;
  localparam int DIRECTED_ROWS   = 25;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    cell_t      cell_val;
    logic [8:0] col;
    logic [7:0] lin;
    logic       fe;
  } pixel_word_t;

  typedef struct packed {
    req_t        op;
    logic [8:0]  idx;
    cell_t       val;
    logic        typed;
    pixel_word_t pix;
  } seed_row_t;

  localparam logic [7:0] RED_LUT [16] = '{
    8'd0, 8'd0, 8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd128,
    8'd255, 8'd255, 8'd255, 8'd128, 8'd0, 8'd128, 8'd0, 8'd255
  };
  localparam logic [7:0] GREEN_LUT [16] = '{
    8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd0,
    8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd128, 8'd255
  };
  localparam logic [7:0] BLUE_LUT [16] = '{
    8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255,
    8'd0, 8'd128, 8'd0, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255
  };

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  logic [1:0] req_type;
  logic [8:0] cell_index;
  logic [3:0] cell_value;
  logic       pix_valid;
  logic       pix_stall;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [3:0] cell_out;
  logic [8:0] column;
  logic [7:0] line;
  logic       frame_end;

  cell_t       row_cur [ROW_CELLS];
  cell_t       row_prev [ROW_CELLS];
  cell_t       chain;
  int          col_pos;
  int          line_pos;
  pixel_word_t pending_pixels [$];
  int          errors;
  int          quiet_cycles;
  bit          tx_burst;
  bit          rx_burst;
  int          fill_left;
  bit          hold_off_pending;

  seed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{REQ_PIXEL,   9'd0,   4'd0,  1'b1, '{8'd0, 8'd0, 8'd0, 4'd0, 9'd0, 8'd0, 1'b0}},
    '{REQ_SEED,    9'd0,   4'd15, 1'b0, '0},
    '{REQ_SEED,    9'd399, 4'd15, 1'b0, '0},
    '{REQ_SEED,    9'd400, 4'd5,  1'b0, '0},
    '{REQ_SEED,    9'd511, 4'd15, 1'b0, '0},
    '{REQ_IGNORE,  9'd511, 4'd15, 1'b0, '0},
    '{REQ_RESTART, 9'd0,   4'd15, 1'b0, '0},
    '{REQ_PIXEL,   9'd0,   4'd0,  1'b1,
      '{8'd255, 8'd255, 8'd255, 4'd15, 9'd0, 8'd0, 1'b0}},
    '{REQ_PIXEL,   9'd511, 4'd15, 1'b1,
      '{8'd255, 8'd255, 8'd255, 4'd15, 9'd1, 8'd0, 1'b0}},
    '{REQ_SEED,    9'd15,  4'd9,  1'b0, '0},
    '{REQ_PIXEL,   9'd170, 4'd5,  1'b0, '0},
    '{REQ_RESTART, 9'd0,   4'd0,  1'b0, '0},
    '{REQ_PIXEL,   9'd0,   4'd0,  1'b0, '0},
    '{REQ_SEED,    9'd1,   4'd6,  1'b0, '0},
    '{REQ_SEED,    9'd256, 4'd10, 1'b0, '0},
    '{REQ_SEED,    9'd255, 4'd3,  1'b0, '0},
    '{REQ_PIXEL,   9'd0,   4'd0,  1'b0, '0},
    '{REQ_PIXEL,   9'd0,   4'd0,  1'b0, '0},
    '{REQ_IGNORE,  9'd0,   4'd0,  1'b0, '0},
    '{REQ_RESTART, 9'd0,   4'd8,  1'b0, '0},
    '{REQ_PIXEL,   9'd0,   4'd0,  1'b0, '0},
    '{REQ_PIXEL,   9'd0,   4'd0,  1'b0, '0},
    '{REQ_SEED,    9'd8,   4'd15, 1'b0, '0},
    '{REQ_PIXEL,   9'd0,   4'd0,  1'b0, '0},
    '{REQ_PIXEL,   9'd0,   4'd0,  1'b0, '0}
  };

  xor_chain_automaton_pixel_gen i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .cell_index (cell_index),
    .cell_value (cell_value),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cell_out   (cell_out),
    .column     (column),
    .line       (line),
    .frame_end  (frame_end)
  );

  always #5 clk = ~clk;

  function automatic bit step_automaton(input req_t op, input logic [8:0] idx,
                                        input cell_t val, output pixel_word_t pix);
    int    c;
    int    l;
    cell_t k;
    bit    row_end;
    bit    frm_end;
    bit    produced;
    pix = '0;
    produced = 1'b0;
    case (op)
      REQ_SEED: begin
        if (idx < ROW_CELLS) begin
          row_cur[idx]  = val;
          row_prev[idx] = '0;
        end
      end
      REQ_RESTART: begin
        chain    = val;
        col_pos  = 0;
        line_pos = 0;
      end
      REQ_PIXEL: begin
        c = (col_pos >= ROW_CELLS) ? 0 : col_pos;
        l = (line_pos >= FRAME_LINES) ? 0 : line_pos;
        k = chain ^ row_prev[c] ^ row_cur[chain];
        chain = k;
        row_cur[c] = k;
        row_end = (c + 1 >= ROW_CELLS);
        frm_end = row_end && (l + 1 >= FRAME_LINES);
        pix = '{RED_LUT[k], GREEN_LUT[k], BLUE_LUT[k], k, 9'(c), 8'(l), frm_end};
        if (row_end) begin
          row_prev = row_cur;
          col_pos  = 0;
          line_pos = frm_end ? 0 : l + 1;
        end else begin
          col_pos  = c + 1;
          line_pos = l;
        end
        produced = 1'b1;
      end
      default: ;
    endcase
    return produced;
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  task automatic send_word(input req_t op, input logic [8:0] idx, input cell_t val,
                           input bit typed, input pixel_word_t typed_pix);
    int          gap;
    pixel_word_t pix;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    gap = (tx_burst || fill_left > 0) ? 0 : $urandom_range(0, 8);
    if (fill_left > 0) fill_left--;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= op;
    cell_index <= idx;
    cell_value <= val;
    do @(posedge clk); while (req_stall);
    if (step_automaton(op, idx, val, pix)) pending_pixels.push_back(typed ? typed_pix : pix);
  endtask

  task automatic drain_pixels();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall before each word, one long hold-off on request
  initial begin
    int n;
    pix_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      if (hold_off_pending) begin
        n = HOLD_OFF_CYCLES;
        hold_off_pending = 1'b0;
      end else begin
        n = rx_burst ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        pix_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      pix_stall <= 1'b0;
      do @(posedge clk); while (!pix_valid);
    end
  end

  always @(posedge clk) begin
    pixel_word_t want;
    if (!rst) begin
      if (pix_valid && !pix_stall) begin
        if (pending_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel word, expected none, actual cell %0d col %0d line %0d",
                   $time, cell_out, column, line);
        end else begin
          want = pending_pixels.pop_front();
          check_field("red", want.r, red);
          check_field("green", want.g, green);
          check_field("blue", want.b, blue);
          check_field("cell_out", want.cell_val, cell_out);
          check_field("column", want.col, column);
          check_field("line", want.lin, line);
          check_field("frame_end", want.fe, frame_end);
        end
      end
      if ((req_valid && !req_stall) || (pix_valid && !pix_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("xor_chain_automaton_pixel_gen verification failed");
        $finish;
      end
    end
  end

  initial begin
    int         r;
    int         counted;
    bit         hold_done;
    bit         drain_done;
    req_t       op;
    logic [8:0] idx;
    cell_t      val;
    clk        = 1'b0;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_type   = REQ_PIXEL;
    cell_index = '0;
    cell_value = '0;
    errors       = 0;
    quiet_cycles = 0;
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    fill_left    = 0;
    hold_off_pending = 1'b0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    counted    = 0;
    foreach (row_cur[i]) begin
      row_cur[i]  = '0;
      row_prev[i] = '0;
    end
    chain    = '0;
    col_pos  = 0;
    line_pos = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].pix);

    while (counted < RANDOM_WORDS) begin
      r   = $urandom_range(0, 999);
      idx = 9'($urandom_range(0, 511));
      val = 4'($urandom_range(0, 15));
      if (r < 3 && counted >= 600) begin
        op = REQ_RESTART;
      end else if (r < 90) begin
        op = REQ_SEED;
        if (r < 50) idx = 9'($urandom_range(0, 15));
      end else if (r < 110) begin
        op = REQ_IGNORE;
      end else begin
        op = REQ_PIXEL;
      end
      send_word(op, idx, val, 1'b0, '0);
      counted++;
      if (counted == 300 && !hold_done) begin
        hold_done = 1'b1;
        hold_off_pending = 1'b1;
        fill_left = 40;
      end
      if (counted == 900 && !drain_done) begin
        drain_done = 1'b1;
        drain_pixels();
      end
    end

    drain_pixels();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("xor_chain_automaton_pixel_gen verification clean");
    end else begin
      $display("xor_chain_automaton_pixel_gen verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/xca_pkg.sv
hw/rtl/xca_cell_ram.sv
hw/rtl/xca_front.sv
hw/rtl/xca_exec.sv
hw/rtl/xor_chain_automaton_pixel_gen.sv
test/xor_chain_automaton_pixel_gen_tb.sv
